>>> rtl/gtg_pkg.sv
// gtg_pkg: widths, constants and the tanh table of the GELU gradient pipeline.
// Stand-alone package; imported by gelu_tanh_gradient.
`default_nettype none

package gtg_pkg;

  // Fraction bits of x_value, grad_out and grad_in
  localparam int FRAC_BITS = 12;

  localparam int UP_SHIFT = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int DN_SHIFT = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;

  // Q.16 constants
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [15:0] C_SQRT2PI = 16'd52290;
  localparam logic [11:0] C_CUBIC   = 12'd2930;
  localparam logic [13:0] C_CUBIC3  = 14'd8791;

  // Internal widths
  localparam int A_W    = 16 + UP_SHIFT;          // |x| in Q.16
  localparam int A2_W   = 2 * A_W - 16;           // a^2
  localparam int A3_W   = A2_W + A_W - 16;        // a^3
  localparam int C3A2_W = A2_W - 2;               // 3*c1*a^2
  localparam int C1A3_W = A3_W - 4;               // c1*a^3
  localparam int DS_W   = (C3A2_W + 1 > 18) ? C3A2_W + 1 : 18;  // 1 + 3*c1*a^2, dinner
  localparam int SUM_MX = (A_W > C1A3_W) ? A_W : C1A3_W;
  localparam int SUM_W  = ((SUM_MX > 20) ? SUM_MX : 20) + 1;
  localparam int S_W    = 20;                     // clamped a + c1*a^3
  localparam int IN_W   = 20;                     // |inner|
  localparam int T_W    = 17;                     // |tanh|, up to 1.0
  localparam int T2_W   = A_W + DS_W - 17;        // second term of the derivative
  localparam int D_W    = ((T2_W > T_W) ? T2_W : T_W) + 2;
  localparam int P_W    = D_W + 16;               // d * g

  // Clamping the sum at 8.0 keeps |inner| >= 4.0 exact
  localparam logic [S_W-1:0] S_MAX = S_W'(1) << (S_W - 1);
  localparam logic [IN_W-1:0] TANH_LIM = IN_W'(4) << 16;

  localparam int NUM_STG = 10;

  typedef struct packed {
    logic                     neg;
    logic signed [15:0]       g;
    logic [A_W-1:0]           a;
    logic [A2_W-1:0]          a2;
    logic [A3_W-1:0]          a3;
    logic [C3A2_W-1:0]        c3a2;
    logic [C1A3_W-1:0]        c1a3;
    logic [DS_W-1:0]          dinner;
    logic [IN_W-1:0]          inner;
    logic [T_W-1:0]           t;
    logic [T_W-1:0]           sech2;
    logic [T_W-1:0]           term1;
    logic [A_W-1:0]           as_m;
    logic signed [D_W-1:0]    d;
    logic signed [P_W-1:0]    p;
    logic signed [15:0]       res;
  } stage_t;

  // tanh at steps of 0.25 from 0 to 4, Q.16
  function automatic logic [15:0] tanh_tab(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd16051;
      5'd2:    v = 16'd30285;
      5'd3:    v = 16'd41625;
      5'd4:    v = 16'd49912;
      5'd5:    v = 16'd55593;
      5'd6:    v = 16'd59320;
      5'd7:    v = 16'd61694;
      5'd8:    v = 16'd63178;
      5'd9:    v = 16'd64096;
      5'd10:   v = 16'd64659;
      5'd11:   v = 16'd65002;
      5'd12:   v = 16'd65212;
      5'd13:   v = 16'd65339;
      5'd14:   v = 16'd65417;
      5'd15:   v = 16'd65464;
      5'd16:   v = 16'd65492;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gelu_tanh_gradient.sv
// gelu_tanh_gradient: ten-stage pipeline for the backward pass of tanh GELU.
// Depends on gtg_pkg (widths, constants, tanh table).
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  x_value_i, grad_out_i (Q4.12)
// output    out        out_valid_o/out_ready_i grad_in_o (Q4.12, saturated)
//
// One request per cycle sustained while out_ready_i takes results; a result moves
// through the stage registers in order and is offered on grad_in_o from the last.
// Each stage is at most one multiplier deep, which sets the stage depth.
// Reset clears the per-stage valid bits only; payload registers are not reset.
// A stall fills bubbles first: a stage loads whenever it is empty or the stage
// after it moves, so in_ready_o drops only when all ten stages hold requests.

module gelu_tanh_gradient
  import gtg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [15:0] x_value_i,
  input  wire logic signed [15:0] grad_out_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [15:0] grad_in_o
);

  stage_t               stage_q [NUM_STG];
  stage_t               stage_d [NUM_STG];
  logic [NUM_STG-1:0]   v_q;
  logic [NUM_STG-1:0]   en;

  // Per-stage load enables, rippling back from the output
  always_comb begin
    en[NUM_STG-1] = !v_q[NUM_STG-1] || out_ready_i;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_STG-1];
  assign grad_in_o   = stage_q[NUM_STG-1].res;

  // Stage datapath
  always_comb begin
    logic [15:0]             m16;
    logic [2*A_W-1:0]        aa;
    logic [A3_W+15:0]        a2a;
    logic [C3A2_W+15:0]      c3p;
    logic [C1A3_W+15:0]      c1p;
    logic [DS_W-1:0]         ds;
    logic [DS_W+15:0]        dinp;
    logic [SUM_W-1:0]        sum;
    logic [S_W-1:0]          s;
    logic [IN_W+15:0]        inp;
    logic [4:0]              idx;
    logic [13:0]             frac;
    logic [15:0]             lo;
    logic [15:0]             hi;
    logic [29:0]             ip;
    logic [33:0]             tt;
    logic [17:0]             t1s;
    logic [A_W+16:0]         asp;
    logic [A_W+DS_W-1:0]     t2p;
    logic [T2_W-1:0]         term2;
    logic [P_W-1:0]          pm;
    logic [P_W-16:0]         rm;

    // Stage 0: magnitude, alignment to Q.16, a^2
    stage_d[0]      = '0;
    stage_d[0].neg  = x_value_i[15];
    stage_d[0].g    = grad_out_i;
    m16             = x_value_i[15] ? 16'(-x_value_i) : 16'(x_value_i);
    stage_d[0].a    = (A_W'(m16) << UP_SHIFT) >> DN_SHIFT;
    aa              = (2*A_W)'(stage_d[0].a) * (2*A_W)'(stage_d[0].a);
    stage_d[0].a2   = aa[A2_W+15:16];

    // Stage 1: a^3 and 3*c1*a^2
    stage_d[1]      = stage_q[0];
    a2a             = (A3_W+16)'(stage_q[0].a2) * (A3_W+16)'(stage_q[0].a);
    stage_d[1].a3   = a2a[A3_W+15:16];
    c3p             = (C3A2_W+16)'(C_CUBIC3) * (C3A2_W+16)'(stage_q[0].a2);
    stage_d[1].c3a2 = c3p[C3A2_W+15:16];

    // Stage 2: c1*a^3 and d(inner)/dx
    stage_d[2]        = stage_q[1];
    c1p               = (C1A3_W+16)'(C_CUBIC) * (C1A3_W+16)'(stage_q[1].a3);
    stage_d[2].c1a3   = c1p[C1A3_W+15:16];
    ds                = DS_W'(stage_q[1].c3a2) + DS_W'(ONE_Q16);
    dinp              = (DS_W+16)'(C_SQRT2PI) * (DS_W+16)'(ds);
    stage_d[2].dinner = dinp[DS_W+15:16];

    // Stage 3: |inner|
    stage_d[3]       = stage_q[2];
    sum              = SUM_W'(stage_q[2].a) + SUM_W'(stage_q[2].c1a3);
    s                = (sum >= SUM_W'(S_MAX)) ? S_MAX : sum[S_W-1:0];
    inp              = (IN_W+16)'(C_SQRT2PI) * (IN_W+16)'(s);
    stage_d[3].inner = inp[IN_W+15:16];

    // Stage 4: |tanh| by table and linear interpolation
    stage_d[4] = stage_q[3];
    idx        = {1'b0, stage_q[3].inner[17:14]};
    frac       = stage_q[3].inner[13:0];
    lo         = tanh_tab(idx);
    hi         = tanh_tab(idx + 5'd1);
    ip         = 30'(hi - lo) * 30'(frac);
    if (stage_q[3].inner >= TANH_LIM) begin
      stage_d[4].t = ONE_Q16;
    end else begin
      stage_d[4].t = T_W'(lo) + T_W'(ip[29:14]);
    end

    // Stage 5: sech^2 and the first term
    stage_d[5]       = stage_q[4];
    tt               = 34'(stage_q[4].t) * 34'(stage_q[4].t);
    stage_d[5].sech2 = T_W'(18'(ONE_Q16) - tt[33:16]);
    if (stage_q[4].neg) begin
      t1s = 18'(ONE_Q16) - 18'(stage_q[4].t);
    end else begin
      t1s = 18'(ONE_Q16) + 18'(stage_q[4].t);
    end
    stage_d[5].term1 = t1s[17:1];

    // Stage 6: a * sech^2
    stage_d[6]      = stage_q[5];
    asp             = (A_W+17)'(stage_q[5].a) * (A_W+17)'(stage_q[5].sech2);
    stage_d[6].as_m = asp[A_W+15:16];

    // Stage 7: second term and the signed derivative
    stage_d[7] = stage_q[6];
    t2p        = (A_W+DS_W)'(stage_q[6].as_m) * (A_W+DS_W)'(stage_q[6].dinner);
    term2      = t2p[A_W+DS_W-1:17];
    if (stage_q[6].neg) begin
      stage_d[7].d = $signed(D_W'(stage_q[6].term1)) - $signed(D_W'(term2));
    end else begin
      stage_d[7].d = $signed(D_W'(stage_q[6].term1)) + $signed(D_W'(term2));
    end

    // Stage 8: d * g
    stage_d[8]   = stage_q[7];
    stage_d[8].p = P_W'(stage_q[7].d) * P_W'(stage_q[7].g);

    // Stage 9: round half away from zero, saturate
    stage_d[9] = stage_q[8];
    pm         = stage_q[8].p[P_W-1] ? P_W'(-stage_q[8].p) : P_W'(stage_q[8].p);
    rm         = (P_W-15)'((pm + P_W'(32768)) >> 16);
    if (stage_q[8].p[P_W-1]) begin
      stage_d[9].res = (rm > (P_W-15)'(32768)) ? 16'sh8000 : 16'(-rm);
    end else begin
      stage_d[9].res = (rm > (P_W-15)'(32767)) ? 16'sh7fff : 16'(rm);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STG; k++) begin
      if (en[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // Input backs up only with every stage full
  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input blocked with a bubble in the pipeline");

  // An accepted request lands in the first stage
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted request lost at stage 0");

  // Interpolated tanh never exceeds 1.0
  a_tanh_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (stage_q[4].t <= ONE_Q16))
    else $error("tanh magnitude above one");

  // Zero upstream gradient gives zero result
  a_zero_grad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NUM_STG-1] && (stage_q[NUM_STG-1].g == 16'sd0)) |-> (grad_in_o == 16'sd0))
    else $error("non-zero result for zero gradient");

endmodule

`default_nettype wire
